[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sharpening filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define DOGSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dog sharpen filter: assertion failed");

// Condition in one cycle requires another condition in the next cycle.
`define DOGSF_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("dog sharpen filter: assertion failed");

`endif

[hw/rtl/dogsf_pkg.sv]
// ----------------------------------------------------------------------------
// Sharpening filter package
// Payload types, window types and constants shared by the filter modules.
// ----------------------------------------------------------------------------
package dogsf_pkg;

  localparam int DOGSF_MAX_WIDTH = 4096;
  localparam int STORED_ROWS     = 6;
  localparam int DIM_W           = 13;
  localparam int ROW_W           = 14;
  localparam int WIDE_W          = 14;
  localparam int NARROW_W        = 12;

  localparam logic [7:0]       GAIN_RESET   = 8'd4;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd4096;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd3000;
  localparam logic [DIM_W-1:0] MIN_DIM      = 13'd4;

  typedef enum logic [1:0] {
    CFG_SHARPEN_GAIN = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       row_end;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  // Column windows handed from the column stage to the result emitter.
  typedef struct packed {
    logic [6:0][WIDE_W-1:0]   wide;
    logic [5:0][NARROW_W-1:0] narrow;
    logic [3:0][7:0]          center;
    logic                     flush;
    logic                     frame_last;
  } emit_load_t;

endpackage

[hw/rtl/dogsf_emit.sv]
// ----------------------------------------------------------------------------
// Result emitter
// Holds one column window snapshot, emits its result and the row-end flush
// results, and computes the sharpened pixel in two register stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dogsf_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            gain_i,
  input  logic                  load_valid_i,
  input  dogsf_pkg::emit_load_t load_i,
  output logic                  load_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dogsf_pkg::out_item_t  out_data_o
);
  import dogsf_pkg::*;

  // Snapshot stage.
  logic                     e_valid_q, e_valid_d;
  logic [1:0]               e_cnt_q, e_cnt_d;
  logic                     e_flush_q, e_flush_d;
  logic                     e_frame_q, e_frame_d;
  logic [6:0][WIDE_W-1:0]   e_wide_q, e_wide_d;
  logic [5:0][NARROW_W-1:0] e_narrow_q, e_narrow_d;
  logic [3:0][7:0]          e_center_q, e_center_d;

  // Quotient stage.
  logic       p_valid_q;
  logic [7:0] p_q5_q, p_q7_q, p_center_q;
  logic [2:0] p_flags_q;

  // Output register.
  logic      o_valid_q;
  out_item_t o_data_q, o_data_d;

  logic        o_ready, p_ready, e_take, e_last;
  logic [15:0] b5;
  logic [19:0] b7;
  logic [2:0]  e_flags;
  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic signed [18:0] sum;

  assign o_ready      = !o_valid_q || !out_stall_i;
  assign p_ready      = !p_valid_q || o_ready;
  assign e_take       = e_valid_q && p_ready;
  assign e_last       = (e_cnt_q == 2'd0);
  assign load_ready_o = !e_valid_q || (e_take && e_last);

  // Flags of the result now presented: row end, frame end, last of the item.
  assign e_flags = {e_last && e_flush_q, e_last && e_flush_q && e_frame_q, e_last};

  always_comb begin
    e_valid_d  = e_valid_q;
    e_cnt_d    = e_cnt_q;
    e_flush_d  = e_flush_q;
    e_frame_d  = e_frame_q;
    e_wide_d   = e_wide_q;
    e_narrow_d = e_narrow_q;
    e_center_d = e_center_q;
    if (load_valid_i && load_ready_o) begin
      e_valid_d  = 1'b1;
      e_cnt_d    = load_i.flush ? 2'd3 : 2'd0;
      e_flush_d  = load_i.flush;
      e_frame_d  = load_i.frame_last;
      e_wide_d   = load_i.wide;
      e_narrow_d = load_i.narrow;
      e_center_d = load_i.center;
    end else if (e_take) begin
      if (e_last) begin
        e_valid_d = 1'b0;
      end else begin
        // Flush step: the right edge column repeats into the window.
        e_cnt_d = e_cnt_q - 2'd1;
        for (int i = 0; i < 6; i++) e_wide_d[i] = e_wide_q[i+1];
        for (int i = 0; i < 5; i++) e_narrow_d[i] = e_narrow_q[i+1];
        for (int i = 0; i < 3; i++) e_center_d[i] = e_center_q[i+1];
      end
    end
  end

  assign b5 = 16'(e_narrow_q[0]) + 16'(e_narrow_q[1]) * 16'd4
            + 16'(e_narrow_q[2]) * 16'd6 + 16'(e_narrow_q[3]) * 16'd4
            + 16'(e_narrow_q[4]);
  assign b7 = 20'(e_wide_q[0]) + 20'(e_wide_q[1]) * 20'd6
            + 20'(e_wide_q[2]) * 20'd15 + 20'(e_wide_q[3]) * 20'd20
            + 20'(e_wide_q[4]) * 20'd15 + 20'(e_wide_q[5]) * 20'd6
            + 20'(e_wide_q[6]);

  always_comb begin
    diff = $signed({1'b0, p_q5_q}) - $signed({1'b0, p_q7_q});
    prod = $signed({1'b0, gain_i}) * diff;
    sum  = $signed({prod[17], prod}) + $signed({11'd0, p_center_q});
    if (sum < 0) begin
      o_data_d.pixel_out = 8'd0;
    end else if (sum > 19'sd255) begin
      o_data_d.pixel_out = 8'd255;
    end else begin
      o_data_d.pixel_out = sum[7:0];
    end
    o_data_d.row_end   = p_flags_q[2];
    o_data_d.frame_end = p_flags_q[1];
    o_data_d.run_last  = p_flags_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      e_cnt_q   <= 2'd0;
      e_flush_q <= 1'b0;
      e_frame_q <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      e_valid_q <= e_valid_d;
      e_cnt_q   <= e_cnt_d;
      e_flush_q <= e_flush_d;
      e_frame_q <= e_frame_d;
      if (p_ready) p_valid_q <= e_valid_q;
      if (o_ready) o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_wide_q   <= e_wide_d;
    e_narrow_q <= e_narrow_d;
    e_center_q <= e_center_d;
    if (p_ready) begin
      p_q5_q     <= b5[15:8];
      p_q7_q     <= b7[19:12];
      p_center_q <= e_center_q[0];
      p_flags_q  <= e_flags;
    end
    if (o_ready) o_data_q <= o_data_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

  `DOGSF_ASSERT(a_cnt_busy, clk_i, rst_ni, (e_cnt_q != 2'd0) |-> (e_valid_q && e_flush_q))
  `DOGSF_ASSERT(a_frame_end_flags, clk_i, rst_ni, (o_valid_q && o_data_q.frame_end) |-> (o_data_q.row_end && o_data_q.run_last))
  `DOGSF_ASSERT_NEXT(a_p_hold, clk_i, rst_ni, p_valid_q && !p_ready, p_valid_q)

endmodule

[hw/rtl/dog_sharpen_filter_core.sv]
// ----------------------------------------------------------------------------
// Difference-of-Gaussians sharpening filter
// Streams an 8-bit plane in raster order and sharpens it with a 5x5 and a
// 7x7 binomial blur over a six-row line store.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, sustained, as long as the output
// side keeps up. Each accepted pixel reads the six line store banks at its
// column; results pass the input, snapshot, quotient and output registers.
// The four results of a row's last pixel are sent one after another by the
// result emitter while the next row's first three columns, which give no
// result, go in. The input stalls only when the output side stalls. The line
// store needs no clearing pass after reset.
`include "assert_macros.svh"

module dog_sharpen_filter_core #(
  parameter int MAX_WIDTH = dogsf_pkg::DOGSF_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [12:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dogsf_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dogsf_pkg::out_item_t out_data_o
);
  import dogsf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [DIM_W:0] MaxWidth = (DIM_W+1)'(MAX_WIDTH);

  logic [7:0]       gain_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W:0]   w_eff;
  logic [CW-1:0]    w_last;
  logic [DIM_W-1:0] h_eff;

  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [2:0]       bank_q;

  logic             b_valid_q, b_drain_q;
  logic [7:0]       b_px_q;
  logic [CW-1:0]    b_col_q;
  logic [ROW_W-1:0] b_row_q;
  logic [2:0]       b_bank_q;

  logic [7:0] mem [STORED_ROWS][MAX_WIDTH];
  logic [7:0] rd_q [STORED_ROWS];

  logic [6:0][WIDE_W-1:0]   mw_q, mw_d;
  logic [5:0][NARROW_W-1:0] mn_q, mn_d;
  logic [3:0][7:0]          mc_q, mc_d;

  logic [6:0][7:0]      tap;
  logic [WIDE_W-1:0]    wsum;
  logic [NARROW_W-1:0]  nsum;
  logic                 accept, take, drain_row, in_drain, geom_wr;
  logic                 b_emit, b_flush, b_frame, b_adv, load_ready;
  emit_load_t           load;

  // Effective geometry.
  always_comb begin
    if (width_q < MIN_DIM) begin
      w_eff = {1'b0, MIN_DIM};
    end else if ({1'b0, width_q} > MaxWidth) begin
      w_eff = MaxWidth;
    end else begin
      w_eff = {1'b0, width_q};
    end
    w_last = CW'(w_eff - (DIM_W+1)'(1));
    h_eff  = (height_q < MIN_DIM) ? MIN_DIM : height_q;
  end

  assign geom_wr   = cfg_we_i && (cfg_idx_i == CFG_FRAME_WIDTH || cfg_idx_i == CFG_FRAME_HEIGHT);
  assign in_drain  = in_data_i.action;
  assign drain_row = (row_q >= {1'b0, h_eff});
  assign accept    = in_valid_i && !in_stall_o;
  // A pixel in a drain row, or a drain tick in a pixel row, is dropped.
  assign take      = accept && (in_drain == drain_row);

  assign b_emit  = (b_row_q >= ROW_W'(3)) && (b_col_q >= CW'(3));
  assign b_flush = (b_row_q >= ROW_W'(3)) && (b_col_q == w_last);
  assign b_frame = (b_row_q == ({1'b0, h_eff} + ROW_W'(2)));
  assign b_adv   = b_valid_q && (!b_emit || load_ready);
  assign in_stall_o = b_valid_q && !b_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RESET;
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      col_q     <= '0;
      row_q     <= '0;
      bank_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHARPEN_GAIN: gain_q   <= cfg_wdata_i[7:0];
          CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (geom_wr) begin
        col_q  <= '0;
        row_q  <= '0;
        bank_q <= '0;
      end else if (take) begin
        if (col_q == w_last) begin
          col_q <= '0;
          if (row_q == ({1'b0, h_eff} + ROW_W'(2))) begin
            row_q  <= '0;
            bank_q <= '0;
          end else begin
            row_q  <= row_q + ROW_W'(1);
            bank_q <= (bank_q == 3'(STORED_ROWS - 1)) ? 3'd0 : bank_q + 3'd1;
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (!in_stall_o) b_valid_q <= take;
    end
  end

  // Line store: one bank per stored row, read before write at the column.
  always_ff @(posedge clk_i) begin
    if (take) begin
      b_drain_q <= in_drain;
      b_px_q    <= in_data_i.pixel_in;
      b_col_q   <= col_q;
      b_row_q   <= row_q;
      b_bank_q  <= bank_q;
      for (int j = 0; j < STORED_ROWS; j++) begin
        rd_q[j] <= mem[j][col_q];
        if (!in_drain && bank_q == 3'(j)) mem[j][col_q] <= in_data_i.pixel_in;
      end
    end
  end

  // Vertical taps: row offset clamped to the top and bottom edges.
  always_comb begin
    logic [2:0] lo, hi, off;
    logic [3:0] bsel;
    for (int k = 0; k < 7; k++) begin
      lo   = (b_row_q < ROW_W'(6 - k)) ? b_row_q[2:0] : 3'(6 - k);
      hi   = b_drain_q ? 3'(b_row_q - {1'b0, h_eff} + ROW_W'(1)) : 3'd0;
      off  = (hi > lo) ? hi : lo;
      bsel = {1'b0, b_bank_q} + 4'(STORED_ROWS) - {1'b0, off};
      if (bsel >= 4'(STORED_ROWS)) bsel = bsel - 4'(STORED_ROWS);
      tap[k] = (off == 3'd0) ? b_px_q : rd_q[bsel[2:0]];
    end
  end

  assign wsum = 14'(tap[0]) + 14'(tap[1]) * 14'd6 + 14'(tap[2]) * 14'd15
              + 14'(tap[3]) * 14'd20 + 14'(tap[4]) * 14'd15 + 14'(tap[5]) * 14'd6
              + 14'(tap[6]);
  assign nsum = 12'(tap[1]) + 12'(tap[2]) * 12'd4 + 12'(tap[3]) * 12'd6
              + 12'(tap[4]) * 12'd4 + 12'(tap[5]);

  // Column windows; the first column of a row fills them as the left edge.
  always_comb begin
    if (b_col_q == '0) begin
      for (int i = 0; i < 7; i++) mw_d[i] = wsum;
      for (int i = 0; i < 6; i++) mn_d[i] = nsum;
      for (int i = 0; i < 4; i++) mc_d[i] = tap[3];
    end else begin
      for (int i = 0; i < 6; i++) mw_d[i] = mw_q[i+1];
      for (int i = 0; i < 5; i++) mn_d[i] = mn_q[i+1];
      for (int i = 0; i < 3; i++) mc_d[i] = mc_q[i+1];
      mw_d[6] = wsum;
      mn_d[5] = nsum;
      mc_d[3] = tap[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      mw_q <= mw_d;
      mn_q <= mn_d;
      mc_q <= mc_d;
    end
  end

  assign load.wide       = mw_d;
  assign load.narrow     = mn_d;
  assign load.center     = mc_d;
  assign load.flush      = b_flush;
  assign load.frame_last = b_frame;

  dogsf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_i       (gain_q),
    .load_valid_i (b_valid_q && b_emit),
    .load_i       (load),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  `DOGSF_ASSERT(a_row_range, clk_i, rst_ni, row_q <= ({1'b0, h_eff} + ROW_W'(2)))
  `DOGSF_ASSERT(a_col_range, clk_i, rst_ni, col_q <= w_last)
  `DOGSF_ASSERT(a_bank_range, clk_i, rst_ni, bank_q < 3'(STORED_ROWS))
  `DOGSF_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, in_stall_o, b_valid_q)

endmodule

[tb/dog_sharpen_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// Sharpening filter core testbench
// Streams small planes through the core with random gaps on both sides.
// A local model of the filter predicts every result, and a checker compares
// each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dog_sharpen_filter_core_tb;
  import dogsf_pkg::*;

  localparam int MAXW = DOGSF_MAX_WIDTH;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [12:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  dog_sharpen_filter_core i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Local copy of the filter state.
  logic [7:0]  line_rows [STORED_ROWS*MAXW];
  int unsigned narrow_sums [5];
  int unsigned wide_sums [7];
  logic [7:0]  centers [4];
  int unsigned col_pos, row_pos;
  int unsigned gain_q, width_q, height_q;

  out_item_t   sharpened_q [$];
  int          errors = 0;
  bit          quiet_tx = 0;
  bit          quiet_rx = 0;
  int          rx_wait = 0;

  function automatic int unsigned act_width();
    if (width_q < 4) return 4;
    if (width_q > MAXW) return MAXW;
    return width_q;
  endfunction

  function automatic int unsigned act_height();
    return (height_q < 4) ? 4 : height_q;
  endfunction

  function automatic void clear_geometry();
    narrow_sums = '{default: 0};
    wide_sums = '{default: 0};
    centers = '{default: 0};
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void shift_wide(int unsigned v);
    for (int k = 0; k < 6; k++) wide_sums[k] = wide_sums[k+1];
    wide_sums[6] = v;
  endfunction

  function automatic void shift_narrow(int unsigned v);
    for (int k = 0; k < 4; k++) narrow_sums[k] = narrow_sums[k+1];
    narrow_sums[4] = v;
  endfunction

  function automatic void shift_center(logic [7:0] v);
    for (int k = 0; k < 3; k++) centers[k] = centers[k+1];
    centers[3] = v;
  endfunction

  function automatic out_item_t sharp_pixel(int unsigned x, int unsigned r,
                                            int unsigned w, int unsigned h);
    int unsigned b5, b7;
    int d, v;
    out_item_t o;
    b5 = narrow_sums[0] + 4*narrow_sums[1] + 6*narrow_sums[2] + 4*narrow_sums[3]
       + narrow_sums[4];
    b7 = wide_sums[0] + 6*wide_sums[1] + 15*wide_sums[2] + 20*wide_sums[3]
       + 15*wide_sums[4] + 6*wide_sums[5] + wide_sums[6];
    d = int'(b5 / 256) - int'(b7 / 4096);
    v = int'(centers[0]) + int'(gain_q) * d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    o.pixel_out = v[7:0];
    o.row_end   = (x == w - 1);
    o.frame_end = (x == w - 1) && (r == h - 1);
    o.run_last  = 1'b0;
    return o;
  endfunction

  function automatic void predict_sharpen(in_item_t it);
    int unsigned w, h, c, ir, rr, wsum, nsum;
    int unsigned v [7];
    int row;
    bit drain;
    out_item_t res [$];
    w = act_width();
    h = act_height();
    c = col_pos;
    ir = row_pos;
    drain = it.action;
    if (c >= w || ir >= h + 3) begin
      clear_geometry();
      c = 0;
      ir = 0;
    end
    if (drain != (ir >= h)) return;
    for (int k = 0; k < 7; k++) begin
      row = int'(ir) - 6 + k;
      rr = (row < 0) ? 0 : row;
      if (rr > h - 1) rr = h - 1;
      if (rr == ir) v[k] = it.pixel_in;
      else v[k] = line_rows[(rr % STORED_ROWS)*MAXW + (c % MAXW)];
    end
    if (!drain) line_rows[(ir % STORED_ROWS)*MAXW + (c % MAXW)] = it.pixel_in;
    wsum = v[0] + 6*v[1] + 15*v[2] + 20*v[3] + 15*v[4] + 6*v[5] + v[6];
    nsum = v[1] + 4*v[2] + 6*v[3] + 4*v[4] + v[5];
    if (c == 0) begin
      wide_sums = '{default: wsum};
      narrow_sums = '{default: nsum};
      centers = '{default: v[3][7:0]};
    end else begin
      shift_wide(wsum);
      shift_center(v[3][7:0]);
    end
    if (ir >= 3 && c >= 3) res.push_back(sharp_pixel(c - 3, ir - 3, w, h));
    if (c != 0) shift_narrow(nsum);
    // The last pixel of a row also flushes the three trailing columns.
    if (ir >= 3 && c == w - 1) begin
      for (int unsigned x = w - 3; x < w; x++) begin
        shift_wide(wide_sums[6]);
        shift_center(centers[3]);
        res.push_back(sharp_pixel(x, ir - 3, w, h));
        shift_narrow(narrow_sums[4]);
      end
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[i]) sharpened_q.push_back(res[i]);
    c++;
    if (c >= w) begin
      c = 0;
      ir++;
      if (ir >= h + 3) ir = 0;
    end
    col_pos = c;
    row_pos = ir;
  endfunction

  // Output side: random stall per result, and the result checker.
  always @(negedge clk_i) begin
    if (rx_wait > 0 && !quiet_rx) begin
      out_stall_i <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_wait <= $urandom_range(0, 10);
      if (sharpened_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        errors++;
      end else begin
        exp_item = sharpened_q.pop_front();
        if (out_data_o.pixel_out !== exp_item.pixel_out) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   exp_item.pixel_out, out_data_o.pixel_out);
          errors++;
        end
        if (out_data_o.row_end !== exp_item.row_end) begin
          $display("%0t: row_end expected %0b actual %0b", $time,
                   exp_item.row_end, out_data_o.row_end);
          errors++;
        end
        if (out_data_o.frame_end !== exp_item.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b", $time,
                   exp_item.frame_end, out_data_o.frame_end);
          errors++;
        end
        if (out_data_o.run_last !== exp_item.run_last) begin
          $display("%0t: run_last expected %0b actual %0b", $time,
                   exp_item.run_last, out_data_o.run_last);
          errors++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(bit action, logic [7:0] px);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{action: action, pixel_in: px};
    do @(posedge clk_i); while (in_stall_o);
    predict_sharpen('{action: action, pixel_in: px});
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [12:0] value);
    in_valid_i <= 1'b0;
    wait (sharpened_q.size() == 0);
    // Trailing columns may still be in flight after the last result.
    repeat (12) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SHARPEN_GAIN: gain_q = value[7:0];
      CFG_FRAME_WIDTH: begin
        width_q = value;
        clear_geometry();
      end
      default: begin
        height_q = value;
        clear_geometry();
      end
    endcase
  endtask

  // One whole plane plus drain rows; noise items of the wrong kind are mixed in.
  task automatic send_plane(int noise_pct, int pix_mode);
    int unsigned w, h;
    logic [7:0] px;
    w = act_width();
    h = act_height();
    for (int unsigned r = 0; r < h + 3; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if ($urandom_range(0, 99) < noise_pct) send_item(r < h, 8'($urandom));
        case (pix_mode)
          0: px = 8'($urandom);
          1: px = ((r + c) % 2) ? 8'hFF : 8'h00;
          default: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        send_item(r >= h, px);
      end
    end
  endtask

  task automatic test_directed_extremes();
    write_reg(CFG_SHARPEN_GAIN, 13'd255);
    write_reg(CFG_FRAME_WIDTH, 13'd4);
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    send_plane(0, 1);
    write_reg(CFG_SHARPEN_GAIN, 13'd0);
    send_plane(0, 2);
  endtask

  task automatic test_ignored_items();
    write_reg(CFG_SHARPEN_GAIN, 13'd4);
    send_item(1'b1, 8'hFF);
    send_plane(40, 0);
  endtask

  task automatic test_geometry_clamps();
    // Undersized width and height act as the minimum.
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    send_plane(0, 0);
    // Oversized width clamps; only part of a row is sent before a restart.
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 20; i++) send_item(1'b0, 8'($urandom));
    // A geometry change mid-frame restarts the plane.
    write_reg(CFG_FRAME_WIDTH, 13'd5);
    write_reg(CFG_FRAME_HEIGHT, 13'd5);
    for (int i = 0; i < 23; i++) send_item(1'b0, 8'($urandom));
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    send_plane(0, 0);
  endtask

  task automatic test_random_planes();
    for (int f = 0; f < 3; f++) begin
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      write_reg(CFG_SHARPEN_GAIN, (f == 0) ? 13'd255 : 13'($urandom_range(0, 255)));
      write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(4, 10)));
      write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(4, 7)));
      send_plane(8, $urandom_range(0, 2));
    end
    // Back-to-back planes without reconfiguration.
    send_plane(0, 0);
    quiet_tx = 0;
    quiet_rx = 0;
  endtask

  initial begin
    line_rows = '{default: 8'h00};
    gain_q = GAIN_RESET;
    width_q = WIDTH_RESET;
    height_q = HEIGHT_RESET;
    clear_geometry();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_ignored_items();
    test_geometry_clamps();
    test_random_planes();
    in_valid_i <= 1'b0;
    wait (sharpened_q.size() == 0);
    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dogsf_pkg.sv
hw/rtl/dogsf_emit.sv
hw/rtl/dog_sharpen_filter_core.sv
tb/dog_sharpen_filter_core_tb.sv
